### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Holds field widths, operation and status codes, and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int FIELD_W   = 32;
	localparam int DEN_W     = 31;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int WIDE_W    = 2 * FIELD_W;
	localparam int SHIFT_W   = $clog2(WIDE_W);
	localparam int WIDTH_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD = 2'd0,
		FUNC_INC = 2'd1,
		FUNC_DEC = 2'd2,
		FUNC_CMP = 2'd3
	} func_t;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		RSEL_A = 2'd0,
		RSEL_B = 2'd1,
		RSEL_S = 2'd2
	} red_sel_t;

	typedef enum logic [1:0] {
		MSEL_P = 2'd0,
		MSEL_Q = 2'd1,
		MSEL_D = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     err_zero;
		logic     red_start;
		red_sel_t red_sel;
		logic     store_a;
		logic     store_b;
		logic     store_b_unit;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_en;
		logic     cmp_en;
		logic     fit_en;
	} dp_cmd_t;

	typedef struct packed {
		logic  zero_den;
		func_t func;
		logic  red_done;
	} dp_stat_t;

	// Magnitude of a two's complement field; the most negative value maps to 2^(n-1).
	function automatic logic [FIELD_W-1:0] mag_of(input logic [FIELD_W-1:0] v);
		mag_of = v[FIELD_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

### rtl/rau_reduce.sv
// ----------------------------------------------------------------------------
// rau_reduce: iterative reduction of a fraction to lowest terms
// Binary GCD, one step per cycle, then a pair of restoring dividers that
// share the divisor and produce one quotient bit per cycle each.
// ----------------------------------------------------------------------------
module rau_reduce (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       neg,
	input  logic [rau_pkg::WIDE_W-1:0] mag,
	input  logic [rau_pkg::WIDE_W-1:0] den,
	output logic                       done,
	output logic                       r_neg,
	output logic [rau_pkg::WIDE_W-1:0] r_mag,
	output logic [rau_pkg::WIDE_W-1:0] r_den
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_GCD  = 4'b0010,
		R_DIV  = 4'b0100,
		R_DONE = 4'b1000
	} red_state_t;

	red_state_t            state_q;
	logic [SHIFT_W-1:0]    cnt_q;
	logic [SHIFT_W-1:0]    k_q;
	logic [WIDE_W-1:0]     u_q, v_q, g_q;
	logic [WIDE_W-1:0]     qm_q, qd_q, rm_q, rd_q;
	logic                  neg_q;
	logic                  gcd_end;
	logic                  can_start;
	logic [WIDE_W:0]       tm, td, gx;
	logic                  ge_m, ge_d;

	assign gcd_end   = (u_q == '0) || (v_q == '0);
	assign can_start = (state_q == R_IDLE) || (state_q == R_DONE);
	assign gx        = {1'b0, g_q};
	assign tm        = {rm_q, qm_q[WIDE_W-1]};
	assign td        = {rd_q, qd_q[WIDE_W-1]};
	assign ge_m      = tm >= gx;
	assign ge_d      = td >= gx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				R_IDLE, R_DONE: begin
					if (start) state_q <= R_GCD;
					else       state_q <= R_IDLE;
				end
				R_GCD: begin
					if (gcd_end) begin
						state_q <= R_DIV;
						cnt_q   <= '0;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SHIFT_W'(WIDE_W - 1)) state_q <= R_DONE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && can_start) begin
			u_q   <= mag;
			v_q   <= den;
			k_q   <= '0;
			qm_q  <= mag;
			qd_q  <= den;
			neg_q <= neg;
		end else if (state_q == R_GCD) begin
			priority if (gcd_end) begin
				g_q  <= ((u_q == '0) ? v_q : u_q) << k_q;
				rm_q <= '0;
				rd_q <= '0;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end else if (state_q == R_DIV) begin
			rm_q <= ge_m ? WIDE_W'(tm - gx) : tm[WIDE_W-1:0];
			rd_q <= ge_d ? WIDE_W'(td - gx) : td[WIDE_W-1:0];
			qm_q <= {qm_q[WIDE_W-2:0], ge_m};
			qd_q <= {qd_q[WIDE_W-2:0], ge_d};
		end
	end

	assign done  = (state_q == R_DONE);
	assign r_mag = qm_q;
	assign r_den = qd_q;
	assign r_neg = neg_q && (qm_q != '0);

endmodule

### rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, the reduction unit, one 32x32 multiplier, the signed
// sum and compare logic, and the result registers.
// ----------------------------------------------------------------------------
module rau_dp #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rau_pkg::dp_cmd_t                   cmd,
	output rau_pkg::dp_stat_t                  stat,
	input  logic [rau_pkg::FUNC_W-1:0]         func,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
	output logic signed [rau_pkg::FIELD_W-1:0] res_num,
	output logic [rau_pkg::DEN_W-1:0]          res_den,
	output logic                               is_less,
	output logic                               is_equal,
	output logic [rau_pkg::STATUS_W-1:0]       status
);
	import rau_pkg::*;

	localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (WIDTH - 1);

	func_t               func_q;
	logic [FIELD_W-1:0]  a_num_q, a_den_q, b_num_q, b_den_q;
	logic                a_neg_q, b_neg_q;
	logic [FIELD_W-1:0]  a_mag_q, a_dr_q, b_mag_q, b_dr_q;
	logic [WIDE_W-1:0]   p_q, q_q, d_q, sum_q;
	logic                sum_neg_q;
	logic                red_neg;
	logic [WIDE_W-1:0]   red_mag, red_den;
	logic                r_done, r_neg;
	logic [WIDE_W-1:0]   r_mag, r_den;
	logic [FIELD_W-1:0]  mul_x, mul_y;
	logic [WIDE_W-1:0]   prod;
	logic                less, fits;
	logic                need_b;

	assign need_b = (func_q == FUNC_ADD) || (func_q == FUNC_CMP);

	assign stat.zero_den = (a_den_q == '0) || (need_b && (b_den_q == '0));
	assign stat.func     = func_q;
	assign stat.red_done = r_done;

	always_comb begin
		unique case (cmd.red_sel)
			RSEL_A: begin
				red_neg = a_num_q[FIELD_W-1] ^ a_den_q[FIELD_W-1];
				red_mag = {{FIELD_W{1'b0}}, mag_of(a_num_q)};
				red_den = {{FIELD_W{1'b0}}, mag_of(a_den_q)};
			end
			RSEL_B: begin
				red_neg = b_num_q[FIELD_W-1] ^ b_den_q[FIELD_W-1];
				red_mag = {{FIELD_W{1'b0}}, mag_of(b_num_q)};
				red_den = {{FIELD_W{1'b0}}, mag_of(b_den_q)};
			end
			default: begin
				red_neg = sum_neg_q;
				red_mag = sum_q;
				red_den = d_q;
			end
		endcase
	end

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.red_start),
		.neg    (red_neg),
		.mag    (red_mag),
		.den    (red_den),
		.done   (r_done),
		.r_neg  (r_neg),
		.r_mag  (r_mag),
		.r_den  (r_den)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_P: begin
				mul_x = a_mag_q;
				mul_y = b_dr_q;
			end
			MSEL_Q: begin
				mul_x = b_mag_q;
				mul_y = a_dr_q;
			end
			default: begin
				mul_x = a_dr_q;
				mul_y = b_dr_q;
			end
		endcase
	end

	assign prod = WIDE_W'(mul_x) * WIDE_W'(mul_y);

	// Ordering by cross products; a zero on both sides is never less.
	always_comb begin
		if (a_neg_q != b_neg_q) less = a_neg_q && ((p_q != '0) || (q_q != '0));
		else if (a_neg_q)       less = p_q > q_q;
		else                    less = p_q < q_q;
	end

	assign fits = (r_den != '0) && (r_den <= LIM - 1'b1) &&
	              (r_neg ? (r_mag <= LIM) : (r_mag <= LIM - 1'b1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func_t'(func);
			a_num_q <= a_num;
			a_den_q <= a_den;
			b_num_q <= b_num;
			b_den_q <= b_den;
		end
		if (cmd.store_a) begin
			a_neg_q <= r_neg;
			a_mag_q <= r_mag[FIELD_W-1:0];
			a_dr_q  <= r_den[FIELD_W-1:0];
		end
		if (cmd.store_b) begin
			b_neg_q <= r_neg;
			b_mag_q <= r_mag[FIELD_W-1:0];
			b_dr_q  <= r_den[FIELD_W-1:0];
		end else if (cmd.store_b_unit) begin
			b_neg_q <= (func_q == FUNC_DEC);
			b_mag_q <= FIELD_W'(1);
			b_dr_q  <= FIELD_W'(1);
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MSEL_P:  p_q <= prod;
				MSEL_Q:  q_q <= prod;
				default: d_q <= prod;
			endcase
		end
		if (cmd.sum_en) begin
			priority if (a_neg_q == b_neg_q) begin
				sum_q     <= p_q + q_q;
				sum_neg_q <= a_neg_q;
			end else if (p_q >= q_q) begin
				sum_q     <= p_q - q_q;
				sum_neg_q <= a_neg_q;
			end else begin
				sum_q     <= q_q - p_q;
				sum_neg_q <= b_neg_q;
			end
		end
		priority if (cmd.err_zero) begin
			res_num  <= '0;
			res_den  <= '0;
			is_less  <= 1'b0;
			is_equal <= 1'b0;
			status   <= ST_ZERO_DEN;
		end else if (cmd.cmp_en) begin
			res_num  <= '0;
			res_den  <= '0;
			is_less  <= less;
			is_equal <= (a_neg_q == b_neg_q) && (a_mag_q == b_mag_q) && (a_dr_q == b_dr_q);
			status   <= ST_OK;
		end else if (cmd.fit_en) begin
			is_less  <= 1'b0;
			is_equal <= 1'b0;
			if (fits) begin
				res_num <= r_neg ? -r_mag[FIELD_W-1:0] : r_mag[FIELD_W-1:0];
				res_den <= r_den[DEN_W-1:0];
				status  <= ST_OK;
			end else begin
				res_num <= '0;
				res_den <= '0;
				status  <= ST_OVERFLOW;
			end
		end else begin
			res_num  <= res_num;
		end
	end

endmodule

### rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing controller of the rational arithmetic unit
// Walks one word through check, reductions, multiplies and result write.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rau_pkg::dp_stat_t  stat,
	output rau_pkg::dp_cmd_t   cmd,
	output logic               busy,
	output logic               done
);
	import rau_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CHECK = 12'b000000000010,
		S_RED_A = 12'b000000000100,
		S_RED_B = 12'b000000001000,
		S_MUL_P = 12'b000000010000,
		S_MUL_Q = 12'b000000100000,
		S_MUL_D = 12'b000001000000,
		S_CMP   = 12'b000010000000,
		S_SUM   = 12'b000100000000,
		S_RSTRT = 12'b001000000000,
		S_RED_S = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        use_b;

	assign use_b = (stat.func == FUNC_ADD) || (stat.func == FUNC_CMP);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.zero_den) begin
					cmd.err_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.red_start = 1'b1;
					cmd.red_sel   = RSEL_A;
					state_d       = S_RED_A;
				end
			end
			S_RED_A: begin
				if (stat.red_done) begin
					cmd.store_a = 1'b1;
					if (use_b) begin
						cmd.red_start = 1'b1;
						cmd.red_sel   = RSEL_B;
						state_d       = S_RED_B;
					end else begin
						cmd.store_b_unit = 1'b1;
						state_d          = S_MUL_P;
					end
				end
			end
			S_RED_B: begin
				if (stat.red_done) begin
					cmd.store_b = 1'b1;
					state_d     = S_MUL_P;
				end
			end
			S_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_P;
				state_d     = S_MUL_Q;
			end
			S_MUL_Q: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_Q;
				state_d     = (stat.func == FUNC_CMP) ? S_CMP : S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_D;
				state_d     = S_SUM;
			end
			S_CMP: begin
				cmd.cmp_en = 1'b1;
				state_d    = S_DONE;
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = S_RSTRT;
			end
			S_RSTRT: begin
				cmd.red_start = 1'b1;
				cmd.red_sel   = RSEL_S;
				state_d       = S_RED_S;
			end
			S_RED_S: begin
				cmd.red_sel = RSEL_S;
				if (stat.red_done) begin
					cmd.fit_en = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

### rtl/rational_arith_unit.sv
// A zero denominator ends a word straight after the check; every other word passes through
// two or three reductions, whose number of GCD steps varies with the operands.
// Throughput: one word at a time; the next start is taken the cycle after done.
// The reduction unit (one binary GCD step, then one quotient bit per cycle) sets the rate.
// The receiver cannot stall: a result is shown for the one cycle that done is high.
// Reset (arst_n low) returns the controller to idle at once; busy and done go low.
// ----------------------------------------------------------------------------
// rational_arith_unit: add, increment, decrement and compare of rationals
// Each operand is brought to canonical form (sign in the numerator, lowest
// terms), then summed by cross multiplication and reduced again, or
// compared by cross products. Results outside the WIDTH range give an
// overflow status.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rau_pkg::FUNC_W-1:0]         func,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
	output logic                               done,
	output logic signed [rau_pkg::FIELD_W-1:0] res_num,
	output logic [rau_pkg::DEN_W-1:0]          res_den,
	output logic                               is_less,
	output logic                               is_equal,
	output logic [rau_pkg::STATUS_W-1:0]       status
);
	import rau_pkg::*;

	// The controller and datapath talk only through these two structures.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller sequences a word: it latches the inputs, checks the
	// denominators, and then steps the datapath through the reductions and
	// multiplies. It raises done for exactly one cycle when the result
	// registers hold the answer, and is idle again in the following cycle.
	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the operands at field width and every product and sum
	// at double width, so no sum or product can wrap before the final range check.
	rau_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.func     (func),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.res_num  (res_num),
		.res_den  (res_den),
		.is_less  (is_less),
		.is_equal (is_equal),
		.status   (status)
	);

endmodule

### rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Watches the command handshake and the shape of the result words.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [rau_pkg::FIELD_W-1:0] res_num,
	input logic [rau_pkg::DEN_W-1:0]          res_den,
	input logic                               is_less,
	input logic                               is_equal,
	input logic [rau_pkg::STATUS_W-1:0]       status
);
	import rau_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not make the unit busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("done not a single-cycle strobe followed by idle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |->
		(res_num == '0 && res_den == '0 && !is_less && !is_equal))
		else $error("error word carries nonzero fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_ZERO_DEN || status == ST_OVERFLOW))
		else $error("undefined status code");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK && res_num != '0) |-> (res_den != '0))
		else $error("nonzero result with zero denominator");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Drives add, increment, decrement and compare words, predicts each result
// with an independent sign-and-magnitude model and checks every strobed
// result against the oldest prediction held in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	import rau_pkg::*;

	// One predicted or observed result word.
	typedef struct {
		logic signed [FIELD_W-1:0] num;
		logic [DEN_W-1:0]          den;
		logic                      lt;
		logic                      eq;
		logic [STATUS_W-1:0]       st;
	} rat_word_t;

	// A rational in canonical form: sign, 64-bit magnitude, 64-bit denominator.
	typedef struct {
		bit        neg;
		bit [63:0] mag;
		bit [63:0] den;
	} canon_t;

	// Scoreboard: predicts each accepted word and matches strobed results in order.
	class rat_scoreboard;
		rat_word_t pending[$];
		int        mismatches;

		function bit [63:0] euclid(bit [63:0] x, bit [63:0] y);
			bit [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function canon_t lowest(bit neg, bit [63:0] mag, bit [63:0] den);
			canon_t    r;
			bit [63:0] g;
			g = euclid(mag, den);
			r.mag = mag / g;
			r.den = den / g;
			r.neg = (r.mag != 0) ? neg : 1'b0;
			return r;
		endfunction

		function canon_t canon(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] d);
			bit [63:0] nm, dm;
			nm = n[FIELD_W-1] ? (64'h1_0000_0000 - 64'(n)) : 64'(n);
			dm = d[FIELD_W-1] ? (64'h1_0000_0000 - 64'(d)) : 64'(d);
			return lowest(n[FIELD_W-1] ^ d[FIELD_W-1], nm, dm);
		endfunction

		// Notes an accepted word and queues the result it must produce.
		function void note_word(func_t f, logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
				logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
			rat_word_t e;
			canon_t    a, b, r;
			bit [63:0] p, q, m, lim;
			bit        s;
			e = '{num: '0, den: '0, lt: 1'b0, eq: 1'b0, st: ST_OK};
			lim = 64'd1 << 31;
			if (ad == 0 || ((f == FUNC_ADD || f == FUNC_CMP) && bd == 0)) begin
				e.st = ST_ZERO_DEN;
				pending.push_back(e);
				return;
			end
			a = canon(an, ad);
			if (f == FUNC_CMP) begin
				b = canon(bn, bd);
				p = a.mag * b.den;
				q = b.mag * a.den;
				if (a.neg != b.neg)
					e.lt = a.neg && (p != 0 || q != 0);
				else if (a.neg)
					e.lt = p > q;
				else
					e.lt = p < q;
				e.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
				pending.push_back(e);
				return;
			end
			if (f == FUNC_ADD)
				b = canon(bn, bd);
			else
				b = '{neg: (f == FUNC_DEC), mag: 64'd1, den: 64'd1};
			p = a.mag * b.den;
			q = b.mag * a.den;
			if (a.neg == b.neg) begin
				m = p + q; s = a.neg;
			end else if (p >= q) begin
				m = p - q; s = a.neg;
			end else begin
				m = q - p; s = b.neg;
			end
			r = lowest(s, m, a.den * b.den);
			if (r.den == 0 || r.den > lim - 1 || r.mag > (r.neg ? lim : lim - 1)) begin
				e.st = ST_OVERFLOW;
			end else begin
				e.num = FIELD_W'(r.neg ? (64'd0 - r.mag) : r.mag);
				e.den = r.den[DEN_W-1:0];
			end
			pending.push_back(e);
		endfunction

		// Checks one strobed result against the oldest prediction.
		function void check_result(rat_word_t got);
			rat_word_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result num=%0d den=%0d", got.num, got.den);
				return;
			end
			e = pending.pop_front();
			if (got.num !== e.num || got.den !== e.den || got.lt !== e.lt ||
					got.eq !== e.eq || got.st !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d/%0d lt=%b eq=%b st=%0d, got %0d/%0d lt=%b eq=%b st=%0d",
						e.num, e.den, e.lt, e.eq, e.st,
						got.num, got.den, got.lt, got.eq, got.st);
			end
		endfunction
	endclass

	logic                      clk, arst_n, start, busy, done, is_less, is_equal;
	logic [FUNC_W-1:0]         func;
	logic signed [FIELD_W-1:0] a_num, a_den, b_num, b_den, res_num;
	logic [DEN_W-1:0]          res_den;
	logic [STATUS_W-1:0]       status;

	rat_scoreboard sb;
	int            send_idle_pct;
	longint        cycles;

	rational_arith_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den), .done(done),
		.res_num(res_num), .res_den(res_den), .is_less(is_less),
		.is_equal(is_equal), .status(status)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Results are sampled at the rising edge; done lasts exactly one cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rat_word_t'{num: res_num, den: res_den, lt: is_less,
				eq: is_equal, st: status});
	end

	// Watchdog: ends the run as failed once the total cycle count passes its limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 64'd10_000_000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Presents one word at a falling edge, holds start until the block takes it.
	// Start is dropped only for idle gaps before a word and by drain; within this
	// task it is never lowered and raised in the same step.
	task automatic send_word(func_t f, logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
			logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		func <= f; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_word(f, an, ad, bn, bd);
		@(negedge clk);
	endtask

	// Field values leaning towards the edges, small numbers and shared factors.
	function automatic logic [FIELD_W-1:0] pick_field();
		case ($urandom_range(7))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7FFF_FFFF - $urandom_range(3);
			2: return $urandom_range(20) - 10;
			3: return ($urandom_range(1) ? -1 : 1) * ($urandom_range(1, 2000) * 360);
			4: return 32'd1 << $urandom_range(31);
			5: return $urandom_range(1000);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(int count, int idle);
		logic [FIELD_W-1:0] ad, bd;
		send_idle_pct = idle;
		repeat (count) begin
			ad = pick_field();
			bd = pick_field();
			// Zero denominators are kept rare so that most words reach the GCD path.
			if (ad == 0 && $urandom_range(3) != 0) ad = 1;
			if (bd == 0 && $urandom_range(3) != 0) bd = 7;
			send_word(func_t'($urandom_range(3)), pick_field(), ad, pick_field(), bd);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ADD;
		a_num = '0; a_den = 32'd1; b_num = '0; b_den = 32'd1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words: every operation, zero denominators, the most negative
		// field, results on the edge of the range and sums that overflow.
		send_word(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_word(FUNC_INC, 32'd3, 32'd4, 32'd9, 32'd0);
		send_word(FUNC_DEC, 32'd1, 32'd1, 32'd0, 32'd0);
		send_word(FUNC_CMP, 32'd2, 32'd4, -32'sd1, -32'sd2);
		send_word(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send_word(FUNC_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
		send_word(FUNC_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
		send_word(FUNC_INC, 32'd5, 32'd0, 32'd1, 32'd1);
		send_word(FUNC_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
		send_word(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd5);
		send_word(FUNC_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
		send_word(FUNC_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
		send_word(FUNC_INC, 32'h7FFF_FFFE, 32'd1, 32'd0, 32'd0);
		send_word(FUNC_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
		send_word(FUNC_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
		send_word(FUNC_ADD, 32'd3, -32'sd6, 32'd1, 32'd2);
		send_word(FUNC_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(FUNC_CMP, 32'd0, 32'd5, 32'd0, -32'sd3);
		send_word(FUNC_CMP, -32'sd1, 32'd3, -32'sd1, 32'd2);
		send_word(FUNC_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1);
		send_word(FUNC_DEC, 32'd0, -32'sd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		random_phase(480, 15);
		// Hold off until every outstanding result is back, then go on.
		drain();
		random_phase(480, 59);
		random_phase(480, 0);

		drain();
		repeat (400) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### sim.f
rtl/rau_pkg.sv
rtl/rau_reduce.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
rtl/rau_checker.sv
tb/sv/tb_top.sv
